/* src/xyh_pkg.sv */
package xyh_pkg;

  typedef logic [63:0] u64_t;
  typedef logic signed [63:0] s64_t;

  // lattice geometry, side is a power of two so that wrap is plain truncation
  localparam int LOG_SIDE = 6;
  localparam int SIDE = 1 << LOG_SIDE;
  localparam int AREA = SIDE * SIDE;
  localparam int AREA_W = 2 * LOG_SIDE;

  // trig table
  localparam int TRIG_ENTRIES = 256;
  localparam int TRIG_W = $clog2(TRIG_ENTRIES);
  localparam int TRIG_Q = TRIG_ENTRIES / 4;
  localparam int EXP_ENTRIES = 256;

  localparam u64_t PIHALF_Q30 = 64'd1686629713;
  localparam u64_t EINV_Q30 = 64'd395007542;
  localparam u64_t ONE_Q30 = 64'd1073741824;

  // neighbour walk: three nearest first, then six next-nearest
  localparam int NB_COUNT = 9;
  localparam int NB_NN = 3;

  localparam int DE_W = 24;

  localparam logic [15:0] RATIO_RESET = 16'd410;
  localparam logic [15:0] BETA_RESET = 16'd640;

  localparam logic signed [31:0] COS_INIT = 32'(AREA * 16384);
  localparam logic signed [44:0] E_RESET = 45'((12288 + 6 * 410) * AREA * 2);

  localparam logic ACT_INIT = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  localparam logic REG_RATIO = 1'b0;
  localparam logic REG_BETA = 1'b1;

  typedef logic [14:0] trig_tab_t [TRIG_Q];
  typedef logic [30:0] exp_tab_t [EXP_ENTRIES];

  typedef struct packed {
    logic signed [15:0] c;
    logic signed [15:0] s;
  } cs_t;

  typedef struct packed {
    logic signed [2:0] dr;
    logic signed [2:0] dc;
  } nb_off_t;

  typedef struct packed {
    logic take_item;
    logic load_totals;
    logic clear_wr;
    logic rd_site;
    logic take_old;
    logic acc_nb;
    logic mul_ratio;
    logic form_de;
    logic mul_beta;
    logic exp_init;
    logic exp_step;
    logic take_ok_cmp;
    logic set_ok;
    logic clr_ok;
    logic commit;
    logic square;
    logic sqrt_init;
    logic sqrt_step;
    logic sat_mag;
    logic load_out;
    logic [3:0] nb_idx;
    logic [3:0] acc_idx;
    logic [AREA_W-1:0] clr_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic de_pos;
    logic z_big;
    logic [3:0] exp_k;
    logic p_ok;
  } dp_stat_t;

  // series term divisors, each one a fixed constant
  function automatic u64_t div_term(input u64_t v, input int d);
    u64_t q;
    case (d)
      1: q = v;
      2: q = v >> 1;
      3: q = v / 64'd3;
      4: q = v >> 2;
      5: q = v / 64'd5;
      6: q = v / 64'd6;
      7: q = v / 64'd7;
      8: q = v >> 3;
      9: q = v / 64'd9;
      10: q = v / 64'd10;
      11: q = v / 64'd11;
      12: q = v / 64'd12;
      20: q = v / 64'd20;
      30: q = v / 64'd30;
      42: q = v / 64'd42;
      56: q = v / 64'd56;
      72: q = v / 64'd72;
      90: q = v / 64'd90;
      110: q = v / 64'd110;
      132: q = v / 64'd132;
      156: q = v / 64'd156;
      182: q = v / 64'd182;
      210: q = v / 64'd210;
      240: q = v / 64'd240;
      272: q = v / 64'd272;
      306: q = v / 64'd306;
      342: q = v / 64'd342;
      380: q = v / 64'd380;
      420: q = v / 64'd420;
      default: q = '0;
    endcase
    return q;
  endfunction

  // quarter-wave table, taylor series in q30 then rounded to q1.14
  function automatic trig_tab_t build_trig(input bit want_sin);
    trig_tab_t tab;
    u64_t x, x2, tc, ts, u;
    s64_t sc, ss, v;
    for (int r = 0; r < TRIG_Q; r++) begin
      x = (u64_t'(r) * 64'd4 * PIHALF_Q30) / TRIG_ENTRIES;
      x2 = (x * x) >> 30;
      tc = ONE_Q30;
      ts = x;
      sc = s64_t'(ONE_Q30);
      ss = s64_t'(x);
      for (int k = 1; k <= 10; k++) begin
        tc = div_term((tc * x2) >> 30, (2 * k - 1) * (2 * k));
        ts = div_term((ts * x2) >> 30, (2 * k) * (2 * k + 1));
        if ((k % 2) == 1) begin
          sc = sc - s64_t'(tc);
          ss = ss - s64_t'(ts);
        end else begin
          sc = sc + s64_t'(tc);
          ss = ss + s64_t'(ts);
        end
      end
      v = want_sin ? ss : sc;
      if (v < 0) v = 0;
      u = (u64_t'(v) + 64'd32768) >> 16;
      if (u > 64'd16384) u = 64'd16384;
      tab[r] = u[14:0];
    end
    return tab;
  endfunction

  // exp(-f/256) in q30 for each fraction byte
  function automatic exp_tab_t build_exp();
    exp_tab_t tab;
    u64_t f, t;
    s64_t sum;
    for (int i = 0; i < EXP_ENTRIES; i++) begin
      f = u64_t'(i) << 22;
      t = ONE_Q30;
      sum = s64_t'(ONE_Q30);
      for (int n = 1; n <= 12; n++) begin
        t = div_term((t * f) >> 30, n);
        if ((n % 2) == 1) sum = sum - s64_t'(t);
        else sum = sum + s64_t'(t);
      end
      if (sum < 0) sum = 0;
      tab[i] = sum[30:0];
    end
    return tab;
  endfunction

  localparam trig_tab_t COS_TAB = build_trig(1'b0);
  localparam trig_tab_t SIN_TAB = build_trig(1'b1);
  localparam exp_tab_t EXP_TAB = build_exp();

  function automatic cs_t trig(input logic [15:0] a);
    logic [TRIG_W-1:0] idx;
    logic [1:0] quad;
    logic [TRIG_W-3:0] r;
    logic signed [15:0] cq, sq;
    cs_t o;
    idx = a[15 -: TRIG_W];
    quad = idx[TRIG_W-1 -: 2];
    r = idx[TRIG_W-3:0];
    cq = signed'(16'(COS_TAB[r]));
    sq = signed'(16'(SIN_TAB[r]));
    case (quad)
      2'd0: begin
        o.c = cq;
        o.s = sq;
      end
      2'd1: begin
        o.c = -sq;
        o.s = cq;
      end
      2'd2: begin
        o.c = -cq;
        o.s = -sq;
      end
      default: begin
        o.c = sq;
        o.s = -cq;
      end
    endcase
    return o;
  endfunction

  function automatic nb_off_t nb_offset(input logic [3:0] idx, input logic odd);
    nb_off_t o;
    o.dr = 3'sd0;
    o.dc = 3'sd0;
    case (idx)
      4'd0: o.dc = odd ? 3'sd1 : -3'sd1;
      4'd1: o.dr = 3'sd1;
      4'd2: o.dr = -3'sd1;
      4'd3: begin
        o.dr = 3'sd1;
        o.dc = -3'sd1;
      end
      4'd4: begin
        o.dr = 3'sd1;
        o.dc = 3'sd1;
      end
      4'd5: begin
        o.dr = -3'sd1;
        o.dc = 3'sd1;
      end
      4'd6: begin
        o.dr = -3'sd1;
        o.dc = -3'sd1;
      end
      4'd7: o.dr = 3'sd2;
      4'd8: o.dr = -3'sd2;
      default: ;
    endcase
    return o;
  endfunction

endpackage

/* src/xyh_update_if.sv */
interface xyh_update_if;
  logic valid;
  logic ready;
  logic action;
  logic [5:0] row;
  logic [5:0] column;
  logic [15:0] step_angle;
  logic [15:0] accept_draw;

  modport source (output valid, action, row, column, step_angle, accept_draw, input ready);
  modport sink (input valid, action, row, column, step_angle, accept_draw, output ready);
endinterface

/* src/xyh_result_if.sv */
interface xyh_result_if;
  logic valid;
  logic ready;
  logic accepted;
  logic signed [44:0] energy_total;
  logic signed [31:0] mag_cos;
  logic signed [31:0] mag_sin;
  logic [26:0] mag_magnitude;

  modport source (output valid, accepted, energy_total, mag_cos, mag_sin, mag_magnitude,
                  input ready);
  modport sink (input valid, accepted, energy_total, mag_cos, mag_sin, mag_magnitude,
                output ready);
endinterface

/* src/xyh_datapath.sv */
module xyh_datapath import xyh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  dp_cmd_t cmd,
  output dp_stat_t stat,
  input  logic [15:0] ratio,
  input  logic [15:0] beta,
  input  logic [5:0] row,
  input  logic [5:0] column,
  input  logic [15:0] step_angle,
  input  logic [15:0] accept_draw,
  output logic accepted,
  output logic signed [44:0] energy_total,
  output logic signed [31:0] mag_cos,
  output logic signed [31:0] mag_sin,
  output logic [26:0] mag_magnitude
);

  logic [LOG_SIDE-1:0] site_r, site_c, nb_r, nb_c;
  logic [15:0] step, draw, olda, newa;
  logic [15:0] mem [AREA];
  logic [AREA_W-1:0] rd_addr;
  logic [15:0] rd_data;
  nb_off_t off;
  cs_t t_new, t_old, c0, c1;
  logic signed [16:0] diff;
  logic signed [17:0] dnn;
  logic signed [18:0] dnnn;
  logic signed [35:0] prod;
  logic signed [DE_W-1:0] de;
  logic [38:0] zp;
  logic [30:0] e;
  logic [60:0] e_mul;
  logic [31:0] p_sum;
  logic ok;
  logic signed [44:0] energy;
  logic signed [31:0] csum, ssum;
  logic [26:0] mag;
  logic signed [33:0] cnext, snext;
  logic signed [45:0] enext;
  logic [44:0] e_init;
  logic [31:0] abs_c, abs_s;
  logic [63:0] sqc_w, sqs_w;
  logic [62:0] sq_c, sq_s;
  logic [63:0] sv, sres, sbit, trial;

  assign newa = olda + step;

  // neighbour address, wrap by truncation
  assign off = nb_offset(cmd.nb_idx, site_r[0] ^ site_c[0]);
  assign nb_r = site_r + LOG_SIDE'(off.dr);
  assign nb_c = site_c + LOG_SIDE'(off.dc);
  assign rd_addr = cmd.rd_site ? {site_r, site_c} : {nb_r, nb_c};

  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      mem[cmd.clr_addr] <= '0;
    end else if (cmd.commit) begin
      mem[{site_r, site_c}] <= newa;
    end
    rd_data <= mem[rd_addr];
  end

  assign t_new = trig(newa - rd_data);
  assign t_old = trig(olda - rd_data);
  assign diff = 17'(t_new.c) - 17'(t_old.c);

  assign e_mul = 61'(e) * 61'(EINV_Q30) + (61'(1) << 29);
  assign p_sum = 32'(e) + 32'd8192;

  assign stat.de_pos = (de > 0);
  assign stat.z_big = |zp[38:26];
  assign stat.exp_k = zp[25:22];
  assign stat.p_ok = (18'(draw) < p_sum[31:14]);

  assign c0 = trig(olda);
  assign c1 = trig(newa);
  assign cnext = 34'(csum) + 34'(c1.c) - 34'(c0.c);
  assign snext = 34'(ssum) + 34'(c1.s) - 34'(c0.s);
  assign enext = 46'(energy) + 46'(de);
  assign e_init = 45'(20'(ratio) * 20'd6 + 20'd12288) * 45'(AREA * 2);

  assign abs_c = csum[31] ? 32'(-csum) : 32'(csum);
  assign abs_s = ssum[31] ? 32'(-ssum) : 32'(ssum);
  assign sqc_w = 64'(abs_c) * 64'(abs_c);
  assign sqs_w = 64'(abs_s) * 64'(abs_s);
  assign trial = sres + sbit;

  // item, neighbour sums, acceptance arithmetic, square root and result register
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      site_r <= LOG_SIDE'(row);
      site_c <= LOG_SIDE'(column);
      step <= step_angle;
      draw <= accept_draw;
    end
    if (cmd.take_old) begin
      olda <= rd_data;
      dnn <= '0;
      dnnn <= '0;
    end
    if (cmd.acc_nb) begin
      if (cmd.acc_idx < 4'(NB_NN)) dnn <= dnn + 18'(diff);
      else dnnn <= dnnn + 19'(diff);
    end
    if (cmd.mul_ratio) prod <= 36'(dnnn) * 36'(signed'({1'b0, ratio}));
    if (cmd.form_de) de <= DE_W'(dnn) + DE_W'((prod + 36'sd2048) >>> 12);
    if (cmd.mul_beta) zp <= 39'(de[DE_W-2:0]) * 39'(beta);
    if (cmd.exp_init) e <= EXP_TAB[zp[21:14]];
    else if (cmd.exp_step) e <= e_mul[60:30];
    if (cmd.square) begin
      sq_c <= sqc_w[62:0];
      sq_s <= sqs_w[62:0];
    end
    if (cmd.sqrt_init) begin
      sv <= 64'(sq_c) + 64'(sq_s);
      sres <= '0;
      sbit <= 64'(1) << 62;
    end else if (cmd.sqrt_step) begin
      if (sv >= trial) begin
        sv <= sv - trial;
        sres <= (sres >> 1) + sbit;
      end else begin
        sres <= sres >> 1;
      end
      sbit <= sbit >> 2;
    end
    if (cmd.load_out) begin
      accepted <= ok;
      energy_total <= energy;
      mag_cos <= csum;
      mag_sin <= ssum;
      mag_magnitude <= mag;
    end
  end

  // running totals, accept flag and saturated magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      energy <= E_RESET;
      csum <= COS_INIT;
      ssum <= '0;
      mag <= '0;
      ok <= 1'b0;
    end else begin
      if (cmd.set_ok) ok <= 1'b1;
      else if (cmd.clr_ok) ok <= 1'b0;
      else if (cmd.take_ok_cmp) ok <= stat.p_ok;
      if (cmd.load_totals) begin
        energy <= signed'(e_init);
        csum <= COS_INIT;
        ssum <= '0;
      end else if (cmd.commit) begin
        if (cnext > 34'sd2147483647) csum <= 32'sh7fffffff;
        else if (cnext < -34'sd2147483648) csum <= 32'sh80000000;
        else csum <= cnext[31:0];
        if (snext > 34'sd2147483647) ssum <= 32'sh7fffffff;
        else if (snext < -34'sd2147483648) ssum <= 32'sh80000000;
        else ssum <= snext[31:0];
        if (enext > 46'sd17592186044415) energy <= 45'sh0fffffffffff;
        else if (enext < -46'sd17592186044416) energy <= 45'sh100000000000;
        else energy <= enext[44:0];
      end
      if (cmd.sat_mag) mag <= (|sres[63:27]) ? '1 : sres[26:0];
    end
  end

endmodule

/* src/xyh_control.sv */
module xyh_control import xyh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_action,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid,
  input  dp_stat_t stat,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SITE, S_OLD, S_NB, S_DEMUL, S_DE, S_ZMUL,
    S_EXPI, S_EXP, S_COMMIT, S_SQ, S_SQI, S_ISQ, S_MAG, S_FIN
  } state_t;

  state_t st;
  logic [AREA_W-1:0] clr_cnt;
  logic [4:0] step_cnt;
  logic init_item;
  logic accept;
  logic out_free;

  assign in_ready = (st == S_IDLE);
  assign accept = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    cmd.nb_idx = (st == S_NB) ? step_cnt[3:0] + 4'd1 : step_cnt[3:0];
    cmd.acc_idx = step_cnt[3:0];
    cmd.clr_addr = clr_cnt;
    case (st)
      S_CLEAR: cmd.clear_wr = 1'b1;
      S_IDLE: begin
        cmd.take_item = accept;
        cmd.load_totals = accept && (in_action == ACT_INIT);
        cmd.set_ok = accept && (in_action == ACT_INIT);
      end
      S_SITE: cmd.rd_site = 1'b1;
      S_OLD: cmd.take_old = 1'b1;
      S_NB: cmd.acc_nb = 1'b1;
      S_DEMUL: cmd.mul_ratio = 1'b1;
      S_DE: cmd.form_de = 1'b1;
      S_ZMUL: begin
        cmd.set_ok = !stat.de_pos;
        cmd.mul_beta = stat.de_pos;
      end
      S_EXPI: begin
        cmd.clr_ok = stat.z_big;
        cmd.exp_init = !stat.z_big;
      end
      S_EXP: begin
        cmd.take_ok_cmp = (step_cnt[3:0] == stat.exp_k);
        cmd.exp_step = (step_cnt[3:0] != stat.exp_k);
      end
      S_COMMIT: cmd.commit = 1'b1;
      S_SQ: cmd.square = 1'b1;
      S_SQI: cmd.sqrt_init = 1'b1;
      S_ISQ: cmd.sqrt_step = 1'b1;
      S_MAG: cmd.sat_mag = 1'b1;
      S_FIN: cmd.load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLEAR;
      clr_cnt <= '0;
      step_cnt <= '0;
      init_item <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (st)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) st <= init_item ? S_FIN : S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            step_cnt <= '0;
            init_item <= (in_action == ACT_INIT);
            st <= (in_action == ACT_INIT) ? S_CLEAR : S_SITE;
          end
        end
        S_SITE: st <= S_OLD;
        S_OLD: st <= S_NB;
        S_NB: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == 5'(NB_COUNT - 1)) st <= S_DEMUL;
        end
        S_DEMUL: st <= S_DE;
        S_DE: st <= S_ZMUL;
        S_ZMUL: st <= stat.de_pos ? S_EXPI : S_COMMIT;
        S_EXPI: begin
          step_cnt <= '0;
          st <= stat.z_big ? S_FIN : S_EXP;
        end
        S_EXP: begin
          if (step_cnt[3:0] == stat.exp_k) st <= stat.p_ok ? S_COMMIT : S_FIN;
          else step_cnt <= step_cnt + 1'b1;
        end
        S_COMMIT: st <= S_SQ;
        S_SQ: st <= S_SQI;
        S_SQI: begin
          step_cnt <= '0;
          st <= S_ISQ;
        end
        S_ISQ: begin
          step_cnt <= step_cnt + 1'b1;
          if (&step_cnt) st <= S_MAG;
        end
        S_MAG: st <= S_FIN;
        S_FIN: if (out_free) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

  a_update_starts: assert property (@(posedge clk) disable iff (rst)
    accept && (in_action == ACT_UPDATE) |=> st == S_SITE)
    else $error("update transfer did not start the site read");

  a_init_sweeps: assert property (@(posedge clk) disable iff (rst)
    accept && (in_action == ACT_INIT) |=> st == S_CLEAR && clr_cnt == '0)
    else $error("init transfer did not start the clearing sweep at entry zero");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !out_valid || out_ready)
    else $error("result register overwritten while still held");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    st == S_FIN && !out_valid |=> st == S_IDLE && out_valid)
    else $error("finished item did not reach the result register");

endmodule

/* src/xy_honeycomb_metropolis_step_unit.sv */
// update transfer: result register loaded after the exponent check if it is out of range,
//   after k e^-1 rounds if the draw rejects, after commit and 32 square root rounds if the
//   change is not positive, after both if the draw keeps (k = 0..15), plus any result stall
// one item in flight; a new update transfer is taken in the cycle after the result loads
// init transfer: clearing sweep of the whole spin memory, then the result register is loaded
// reset (synchronous, active high) loads the totals and runs the same sweep before any transfer
module xy_honeycomb_metropolis_step_unit import xyh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [0:0] cfg_index,
  input  logic [15:0] cfg_data,
  xyh_update_if.sink update,
  xyh_result_if.source result
);

  // configuration registers
  logic [15:0] ratio;
  logic [15:0] beta;

  // controller to datapath
  dp_cmd_t cmd;
  dp_stat_t stat;

  // simple write port, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio <= RATIO_RESET;
      beta <= BETA_RESET;
    end else if (cfg_write) begin
      case (cfg_index[0])
        REG_RATIO: ratio <= cfg_data;
        REG_BETA: beta <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: clearing sweep, site and neighbour reads, acceptance, commit, square root
  xyh_control u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (update.valid),
    .in_action (update.action),
    .in_ready  (update.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // spin memory, trig and exp tables, totals and the result register
  xyh_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .ratio         (ratio),
    .beta          (beta),
    .row           (update.row),
    .column        (update.column),
    .step_angle    (update.step_angle),
    .accept_draw   (update.accept_draw),
    .accepted      (result.accepted),
    .energy_total  (result.energy_total),
    .mag_cos       (result.mag_cos),
    .mag_sin       (result.mag_sin),
    .mag_magnitude (result.mag_magnitude)
  );

endmodule
